@@ hdl/clu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types and character codes of the content line unfolder.
// ----------------------------------------------------------------------------
package clu_pkg;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] line_byte;
    logic       last;
  } result_t;

  function automatic result_t make_data(input logic [7:0] b);
    result_t r;
    r.kind      = KIND_DATA;
    r.line_byte = b;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic result_t make_eol();
    result_t r;
    r.kind      = KIND_EOL;
    r.line_byte = 8'h00;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/clu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_if
// Valid/ready channels of the content line unfolder: raw text in, lines out.
// ----------------------------------------------------------------------------
interface clu_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] text_byte;

  modport source (output valid, output mode, output text_byte, input ready);
  modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

interface clu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] line_byte;
  logic       last;

  modport source (output valid, output kind, output line_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input line_byte, input last,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/content_line_unfolder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// content_line_unfolder_core
// Unfolds folded content lines from a byte stream into logical lines.
// ----------------------------------------------------------------------------
//   channel    dir  payload                        transaction
//   text_in    in   mode, text_byte                valid & ready
//   line_out   out  kind, line_byte, last          valid & ready
//
// One input transaction per cycle while text_in.ready is high; its results
// land in the output register in the next cycle. A transaction with two
// results fills a second slot, and text_in holds ready low until that slot
// moves to the output. Synchronous reset returns the line state to the
// start of a text and empties both result slots. A stall on line_out stalls
// text_in once the output register is full and not taken.
// ----------------------------------------------------------------------------
module content_line_unfolder_core (
  input  wire logic clk,
  input  wire logic rst,
  clu_in_if.sink    text_in,
  clu_out_if.source line_out
);
  import clu_pkg::*;

  logic have_line, at_raw_start, cr_pending;
  logic have_line_next, at_raw_start_next, cr_pending_next;

  result_t slot_a, slot_b;
  logic    a_valid, b_valid;

  logic       in_fire, a_take;
  logic [1:0] n_res;
  result_t    r0, r1;
  logic [7:0] b;

  assign a_take        = a_valid && line_out.ready;
  assign text_in.ready = !b_valid && (!a_valid || line_out.ready);
  assign in_fire       = text_in.valid && text_in.ready;
  assign b             = text_in.text_byte;

  assign line_out.valid     = a_valid;
  assign line_out.kind      = slot_a.kind;
  assign line_out.line_byte = slot_a.line_byte;
  assign line_out.last      = slot_a.last;

  always_comb begin
    have_line_next    = have_line;
    at_raw_start_next = at_raw_start;
    cr_pending_next   = cr_pending;
    n_res             = 2'd0;
    r0                = make_eol();
    r1                = make_eol();
    if (text_in.mode == MODE_END) begin
      n_res             = (at_raw_start && have_line) ? 2'd2 : 2'd1;
      have_line_next    = 1'b0;
      at_raw_start_next = 1'b1;
      cr_pending_next   = 1'b0;
    end else if (at_raw_start) begin
      if ((b == CHAR_SP || b == CHAR_TAB) && have_line) begin
        at_raw_start_next = 1'b0;
      end else begin
        have_line_next = 1'b1;
        r0 = have_line ? make_eol() : make_data(b);
        r1 = make_data(b);
        if (b == CHAR_LF) begin
          n_res = {1'b0, have_line};
        end else if (b == CHAR_CR) begin
          n_res             = {1'b0, have_line};
          cr_pending_next   = 1'b1;
          at_raw_start_next = 1'b0;
        end else begin
          n_res             = have_line ? 2'd2 : 2'd1;
          at_raw_start_next = 1'b0;
        end
      end
    end else if (cr_pending) begin
      r0 = make_data(CHAR_CR);
      r1 = make_data(b);
      if (b == CHAR_LF) begin
        cr_pending_next   = 1'b0;
        at_raw_start_next = 1'b1;
      end else if (b == CHAR_CR) begin
        n_res = 2'd1;
      end else begin
        n_res           = 2'd2;
        cr_pending_next = 1'b0;
      end
    end else begin
      r0 = make_data(b);
      if (b == CHAR_CR) begin
        cr_pending_next = 1'b1;
      end else if (b == CHAR_LF) begin
        at_raw_start_next = 1'b1;
      end else begin
        n_res = 2'd1;
      end
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_line    <= 1'b0;
      at_raw_start <= 1'b1;
      cr_pending   <= 1'b0;
    end else if (in_fire) begin
      have_line    <= have_line_next;
      at_raw_start <= at_raw_start_next;
      cr_pending   <= cr_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (b_valid) begin
      if (a_take) begin
        slot_a  <= slot_b;
        b_valid <= 1'b0;
      end
    end else if (in_fire) begin
      a_valid <= (n_res != 2'd0);
      b_valid <= (n_res == 2'd2);
      slot_a  <= r0;
      slot_b  <= r1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
